FILE: rtl/tdud_pkg.sv
// Shared types, constants and bit-shuffle functions for the teletext data unit demux.
package tdud_pkg;

  localparam int UNIT_LEN   = 46;
  localparam int POS_W      = 6;
  localparam int FIFO_DEPTH = 4;

  localparam logic [POS_W-1:0] POS_ID       = 6'd0;
  localparam logic [POS_W-1:0] POS_LEN      = 6'd1;
  localparam logic [POS_W-1:0] PACKET_START = 6'd4;
  localparam logic [POS_W-1:0] ADDR2_POS    = 6'd5;
  localparam logic [POS_W-1:0] LAST_POS     = 6'(UNIT_LEN - 1);

  localparam logic [7:0] ID_A     = 8'h02;
  localparam logic [7:0] ID_B     = 8'h03;
  localparam logic [7:0] LEN_CODE = 8'h2C;
  localparam logic [2:0] MAG_MASK = 3'h7;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic [2:0] magazine;
    logic [4:0] packet_row;
    logic       last_byte;
  } res_t;

  // Up to two results per input item, r0 goes out first.
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic logic [7:0] bit_rev(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7-i] = v[i];
    end
    return r;
  endfunction

  // Hamming 8/4 data bits, no correction.
  function automatic logic [3:0] ham84_data(input logic [7:0] v);
    return {v[7], v[5], v[3], v[1]};
  endfunction

endpackage

FILE: rtl/tdud_parse.sv
// Input register, unit framing counter and per-byte decode into result items.
module tdud_parse (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [7:0]       in_stream_byte,
  output logic             in_stall,
  input  logic             room,
  output tdud_pkg::push_t  push
);

  logic                        stg_vld_r;
  logic [7:0]                  stg_byte_r;
  logic [tdud_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic                        acc_r, acc_nxt;
  logic [7:0]                  held_r;
  logic [7:0]                  mr_r;
  logic                        load, fire;
  logic [7:0]                  rev;
  logic [7:0]                  mr_new;
  logic                        in_packet;

  assign in_stall = stg_vld_r & ~room;
  assign load     = ~in_stall;
  assign fire     = stg_vld_r & room;

  assign rev       = tdud_pkg::bit_rev(stg_byte_r);
  assign mr_new    = {tdud_pkg::ham84_data(rev), tdud_pkg::ham84_data(held_r)};
  assign in_packet = acc_r && (pos_r >= tdud_pkg::PACKET_START);

  always_comb begin
    pos_nxt = (pos_r == tdud_pkg::LAST_POS) ? '0 : pos_r + 1'b1;
    acc_nxt = acc_r;
    if (pos_r == tdud_pkg::POS_ID) begin
      acc_nxt = (stg_byte_r == tdud_pkg::ID_A) || (stg_byte_r == tdud_pkg::ID_B);
    end else if (pos_r == tdud_pkg::POS_LEN) begin
      acc_nxt = acc_r && (stg_byte_r == tdud_pkg::LEN_CODE);
    end
  end

  always_comb begin
    push = '0;
    push.r0.packet_byte = rev;
    push.r0.magazine    = mr_r[2:0] & tdud_pkg::MAG_MASK;
    push.r0.packet_row  = mr_r[7:3];
    push.r0.last_byte   = (pos_r == tdud_pkg::LAST_POS);
    push.r1             = push.r0;
    if (fire && in_packet) begin
      if (pos_r == tdud_pkg::ADDR2_POS) begin
        // both address bytes leave together, tagged with the fresh address
        push.cnt            = 2'd2;
        push.r0.packet_byte = held_r;
        push.r0.magazine    = mr_new[2:0] & tdud_pkg::MAG_MASK;
        push.r0.packet_row  = mr_new[7:3];
        push.r0.last_byte   = 1'b0;
        push.r1.packet_byte = rev;
        push.r1.magazine    = push.r0.magazine;
        push.r1.packet_row  = push.r0.packet_row;
        push.r1.last_byte   = 1'b0;
      end else if (pos_r != tdud_pkg::PACKET_START) begin
        push.cnt = 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
      pos_r     <= '0;
      acc_r     <= 1'b0;
    end else begin
      if (load) begin
        stg_vld_r <= in_valid;
      end
      if (fire) begin
        pos_r <= pos_nxt;
        acc_r <= acc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      stg_byte_r <= in_stream_byte;
    end
    if (fire && in_packet && pos_r == tdud_pkg::PACKET_START) begin
      held_r <= rev;
    end
    if (fire && in_packet && pos_r == tdud_pkg::ADDR2_POS) begin
      mr_r <= mr_new;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= tdud_pkg::LAST_POS)
    else $error("unit position out of range");

  a_pair_pos: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt == 2'd2 |-> pos_r == tdud_pkg::ADDR2_POS && fire)
    else $error("address pair pushed outside second address byte");

  a_push_kept: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt != 2'd0 |-> acc_r && pos_r > tdud_pkg::PACKET_START && push.cnt != 2'd3)
    else $error("result pushed from rejected unit or header");

endmodule

FILE: rtl/tdud_fifo.sv
// Result queue: takes up to two items per cycle, hands out one per cycle while out_stall is low.
module tdud_fifo #(
  parameter int DEPTH = tdud_pkg::FIFO_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  tdud_pkg::push_t push,
  output logic            room,
  output logic            out_valid,
  input  logic            out_stall,
  output tdud_pkg::res_t  out_res
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tdud_pkg::res_t     mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [PTR_W-1:0]   wr1, wr2, rd1;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               pop;

  assign out_valid = (cnt_r != '0);
  assign out_res   = mem_r[rd_ptr_r];
  assign pop       = out_valid & ~out_stall;

  // two free slots after this cycle's pop
  assign room = (cnt_r - CNT_W'(pop)) <= CNT_W'(DEPTH - 2);

  assign wr1 = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign wr2 = (wr1 == PTR_W'(DEPTH - 1)) ? '0 : wr1 + 1'b1;
  assign rd1 = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;

  assign cnt_nxt = cnt_r + CNT_W'(push.cnt) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (pop) begin
        rd_ptr_r <= rd1;
      end
      unique case (push.cnt)
        2'd1:    wr_ptr_r <= wr1;
        2'd2:    wr_ptr_r <= wr2;
        default: wr_ptr_r <= wr_ptr_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr1] <= push.r1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0 && push.cnt != 2'd0) |=> out_valid)
    else $error("pushed item not presented");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && push.cnt == 2'd0) |=> cnt_r == $past(cnt_r) - 1'b1)
    else $error("queue count wrong after pop");

endmodule

FILE: rtl/teletext_data_unit_demux_unit.sv
// Top level of the teletext data unit demux.
//
// Input channel (in_*): one raw byte per item of a stream cut into 46-byte
// data units. Framing is purely positional from reset: byte 0 is the unit id,
// byte 1 the length, bytes 2-3 are skipped, bytes 4..45 are the packet.
// A unit is kept when its id is 0x02 or 0x03 and its length is 0x2C.
// Result channel (out_*): each packet byte of a kept unit, bit-reversed and
// tagged with magazine (0 means 8) and packet row taken from the two Hamming
// 8/4 address bytes without correction. The first address byte is held; both
// come out back to back once the second arrives. out_last_byte marks byte 45.
// An accepted byte waits in the input register until the result queue has
// room for two more items, is then written into the queue and is shown on
// out_* once it reaches the queue's head. Throughput: one byte per cycle
// while out_stall is low, bounded by the result port's one item per cycle;
// a kept unit gives 42 results for 46 bytes; the queue drains between units.
// Reset (rst_n low, synchronous) empties the queue and restarts framing at a
// unit's id byte. When out_stall is held the queue fills; once it cannot
// take two more items the input register holds and in_stall rises.
module teletext_data_unit_demux_unit #(
  parameter int FIFO_DEPTH = tdud_pkg::FIFO_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_stream_byte,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_packet_byte,
  output logic [2:0] out_magazine,
  output logic [4:0] out_packet_row,
  output logic       out_last_byte
);

  tdud_pkg::push_t push;
  tdud_pkg::res_t  res;
  logic            room;

  // Framing, address decode and input register.
  tdud_parse u_parse (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stream_byte (in_stream_byte),
    .in_stall       (in_stall),
    .room           (room),
    .push           (push)
  );

  // Result queue; absorbs the two-item burst of the address pair.
  tdud_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  assign out_packet_byte = res.packet_byte;
  assign out_magazine    = res.magazine;
  assign out_packet_row  = res.packet_row;
  assign out_last_byte   = res.last_byte;

endmodule

FILE: tb/teletext_data_unit_demux_unit_test.sv
// Testbench for the teletext data unit demux: random and directed units against a predictor.
`timescale 1ns / 1ps

module teletext_data_unit_demux_unit_test;
  import tdud_pkg::*;

  // Slowest correct run: ~1300 items, each with the longest idle gap on the input
  // side, every result waiting out the longest receiver stall, plus one long
  // hold of LONG_HOLD_CYCLES. The limit below is several times that.
  localparam int CYCLE_LIMIT      = 400000;
  localparam int RANDOM_UNITS     = 22;
  localparam int LONG_HOLD_CYCLES = 300;
  // Results pass the input register and the result queue; allow margin.
  localparam int DRAIN_CYCLES     = 8;
  localparam int REPORT_CAP       = 50;

  // Keeps its own copy of the framing state and predicts the tagged packet
  // bytes that each accepted stream byte releases.
  class packet_scoreboard;
    bit [POS_W-1:0] frame_pos;
    bit             unit_kept;
    bit [7:0]       held_addr;
    bit [7:0]       addr_code;
    res_t           pending_packet_bytes[$];
    int             error_count;

    function new();
      frame_pos   = '0;
      unit_kept   = 1'b0;
      held_addr   = '0;
      addr_code   = '0;
      error_count = 0;
    endfunction

    function void queue_packet_byte(input bit [7:0] b, input bit is_last);
      res_t r;
      r.packet_byte = b;
      r.magazine    = addr_code[2:0] & MAG_MASK;
      r.packet_row  = addr_code[7:3];
      r.last_byte   = is_last;
      pending_packet_bytes.push_back(r);
    endfunction

    // Called once per accepted input item.
    function void note_stream_byte(input bit [7:0] raw);
      bit [7:0] flipped;
      for (int i = 0; i < 8; i++) begin
        flipped[7-i] = raw[i];
      end
      if (frame_pos == POS_ID) begin
        unit_kept = (raw == ID_A) || (raw == ID_B);
      end else if (frame_pos == POS_LEN) begin
        unit_kept = unit_kept && (raw == LEN_CODE);
      end else if (frame_pos >= PACKET_START && unit_kept) begin
        if (frame_pos == PACKET_START) begin
          held_addr = flipped;
        end else if (frame_pos == ADDR2_POS) begin
          // Data bits 7,5,3,1 of each address byte, no correction.
          addr_code = {flipped[7], flipped[5], flipped[3], flipped[1],
                       held_addr[7], held_addr[5], held_addr[3], held_addr[1]};
          queue_packet_byte(held_addr, 1'b0);
          queue_packet_byte(flipped, 1'b0);
        end else begin
          queue_packet_byte(flipped, frame_pos == LAST_POS);
        end
      end
      frame_pos = (frame_pos == LAST_POS) ? '0 : frame_pos + 1'b1;
    endfunction

    function void report(input string what, input int exp_v, input int act_v);
      error_count++;
      if (error_count <= REPORT_CAP)
        $display("%0t: %s expected %0h actual %0h", $time, what, exp_v, act_v);
    endfunction

    // Called once per accepted result item.
    function void check_packet_byte(input bit [7:0] b, input bit [2:0] mag,
                                    input bit [4:0] row, input bit last);
      res_t e;
      if (pending_packet_bytes.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_CAP)
          $display("%0t: unexpected item, expected none actual byte %0h mag %0h row %0h",
                   $time, b, mag, row);
        return;
      end
      e = pending_packet_bytes.pop_front();
      if (e.packet_byte != b)  report("packet_byte", int'(e.packet_byte), int'(b));
      if (e.magazine != mag)   report("magazine", int'(e.magazine), int'(mag));
      if (e.packet_row != row) report("packet_row", int'(e.packet_row), int'(row));
      if (e.last_byte != last) report("last_byte", int'(e.last_byte), int'(last));
    endfunction

    function int pending_count();
      return pending_packet_bytes.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic [7:0] in_stream_byte = 8'h00;
  logic       in_stall;
  logic       out_valid;
  logic       out_stall = 1'b1;
  logic [7:0] out_packet_byte;
  logic [2:0] out_magazine;
  logic [4:0] out_packet_row;
  logic       out_last_byte;

  packet_scoreboard sb = new();

  bit [7:0] unit_buf [UNIT_LEN];
  bit       send_calm;       // no input gaps for the current unit
  bit       hold_request;    // asks the receiver for one long hold-off
  int       cycle_count = 0;

  teletext_data_unit_demux_unit uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stream_byte (in_stream_byte),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_packet_byte(out_packet_byte),
    .out_magazine   (out_magazine),
    .out_packet_row (out_packet_row),
    .out_last_byte  (out_last_byte)
  );

  always #5 clk = ~clk;

  // Watchdog: a hung handshake or lost result ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one; none at all in calm stretches.
  function automatic int idle_length(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Receiver: samples the result port at each edge, then picks the stall
  // for the next cycle. Calm stretches and one long hold-off are mixed in.
  initial begin
    int stall_left;
    int hold_left;
    bit recv_calm;
    bit hold_taken;
    stall_left = 0;
    hold_left  = 0;
    recv_calm  = 1'b0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        sb.check_packet_byte(out_packet_byte, out_magazine, out_packet_row,
                             out_last_byte);
      if (cycle_count % 128 == 0)
        recv_calm = ($urandom_range(0, 3) == 0);
      if (hold_request && !hold_taken) begin
        hold_left  = LONG_HOLD_CYCLES;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        stall_left = idle_length(recv_calm);
      end
    end
  end

  // One item: hold valid and payload until the block takes it, then maybe idle.
  task automatic send_byte(input bit [7:0] b);
    int gap;
    in_valid       <= 1'b1;
    in_stream_byte <= b;
    do @(posedge clk); while (in_stall);
    sb.note_stream_byte(b);
    gap = idle_length(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_unit();
    for (int i = 0; i < UNIT_LEN; i++) begin
      send_byte(unit_buf[i]);
    end
  endtask

  // Header bytes given, line/framing bytes and packet bytes random.
  task automatic fill_unit(input bit [7:0] id, input bit [7:0] len);
    unit_buf[0] = id;
    unit_buf[1] = len;
    for (int i = 2; i < UNIT_LEN; i++) begin
      unit_buf[i] = 8'($urandom_range(0, 255));
    end
  endtask

  // Sender stops until every predicted result has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int kind;
    bit [7:0] id_byte;
    bit [7:0] len_byte;
    hold_request = 1'b0;
    send_calm    = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: kept unit with all-ones address (magazine 7, row 31) and
    // alternating all-zero / all-one packet bytes.
    fill_unit(ID_A, LEN_CODE);
    unit_buf[PACKET_START] = 8'hFF;
    unit_buf[ADDR2_POS]    = 8'hFF;
    for (int i = ADDR2_POS + 1; i < UNIT_LEN; i++) begin
      unit_buf[i] = i[0] ? 8'hFF : 8'h00;
    end
    send_unit();

    // Kept unit with the other id, all-zero address (magazine 8, row 0).
    send_calm = 1'b1;
    fill_unit(ID_B, LEN_CODE);
    unit_buf[PACKET_START] = 8'h00;
    unit_buf[ADDR2_POS]    = 8'h00;
    send_unit();
    send_calm = 1'b0;

    // Rejected units: good id with a wrong length, a bad id with the right
    // length, and all-ones header bytes. None of these should give output.
    fill_unit(ID_A, LEN_CODE ^ 8'h01);
    send_unit();
    fill_unit(8'h00, LEN_CODE);
    send_unit();
    fill_unit(8'hFF, 8'hFF);
    send_unit();

    // Kept unit right after rejects, to see framing held its place.
    fill_unit(ID_B, LEN_CODE);
    send_unit();
    wait_drained();

    // Random part: mostly well-formed units with random content, the rest
    // broken headers or pure noise.
    for (int u = 0; u < RANDOM_UNITS; u++) begin
      kind     = $urandom_range(0, 9);
      id_byte  = $urandom_range(0, 1) ? ID_A : ID_B;
      len_byte = LEN_CODE;
      if (u == 2) kind = 0;
      if (kind == 7) begin
        len_byte = 8'($urandom_range(0, 255));
        if (len_byte == LEN_CODE) len_byte ^= 8'h01 << $urandom_range(0, 7);
      end else if (kind == 8) begin
        id_byte = 8'($urandom_range(0, 255));
        if (id_byte == ID_A || id_byte == ID_B) id_byte ^= 8'h80;
      end else if (kind == 9) begin
        id_byte  = 8'($urandom_range(0, 255));
        len_byte = 8'($urandom_range(0, 255));
      end
      fill_unit(id_byte, len_byte);
      send_calm = ($urandom_range(0, 3) == 0);
      // Long receiver hold while the sender keeps pushing a kept unit, so
      // the result queue fills and the input side stalls.
      if (u == 2) begin
        send_calm    = 1'b1;
        hold_request = 1'b1;
      end
      send_unit();
      if (u == RANDOM_UNITS / 2) wait_drained();
    end

    wait_drained();
    if (sb.error_count == 0 && sb.pending_count() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/tdud_pkg.sv
rtl/tdud_parse.sv
rtl/tdud_fifo.sv
rtl/teletext_data_unit_demux_unit.sv
tb/teletext_data_unit_demux_unit_test.sv
